// ----- hw/rtl/pcxrle_pkg.sv -----
// Shared types and constants for the PCX run-length line decoder.
package pcxrle_pkg;

    localparam logic [7:0]  CODE_MASK     = 8'hC0;
    localparam logic [7:0]  COUNT_MASK    = 8'h3F;
    localparam logic [15:0] BPL_RESET     = 16'd1;
    localparam logic [16:0] LINES_RESET   = 17'd1;
    localparam int          QUEUE_DEPTH   = 2;
    localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam logic        ADDR_BPL      = 1'b0;
    localparam logic        ADDR_LINES    = 1'b1;

    typedef struct packed {
        logic [7:0] pixel;
        logic [5:0] count;
        logic       line_end;
        logic       image_end;
        logic       status;
    } t_cmd;

    typedef struct packed {
        logic        rearm;
        logic [15:0] bpl;
        logic [16:0] lines;
    } t_rearm;

endpackage

// ----- hw/rtl/pcx_rle_line_decoder.sv -----
// Top level of the PCX run-length line decoder with its register port.
// A literal byte gives one pixel and a count byte gives nothing. A run of n
// pixels holds the expander while it gives one pixel per cycle (less when
// m_axis_tready is low), and input stalls once the two-entry command queue
// between the front end and the expander is full. Line and image position are
// tracked in the front end as bytes are taken, so a run is checked against the
// line in the same cycle as its byte is taken. A write to either register
// rearms the decoder; there is no clearing pass after reset.
module pcx_rle_line_decoder
    import pcxrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // code_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // pixel
    output logic        m_axis_tlast,   // line_end
    output logic [2:0]  m_axis_tuser    // image_end, status, run_last
);

    logic [15:0] r_bpl, n_bpl;
    logic [16:0] r_lines, n_lines;
    logic        w_wr;
    t_rearm      w_rearm;
    logic        w_push;
    t_cmd        w_cmd;
    logic        w_pop;
    t_cmd        w_head;
    logic        w_empty;
    logic        w_full;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_bpl   = r_bpl;
        n_lines = r_lines;
        if (w_wr) begin
            unique case (paddr[2])
                ADDR_BPL:   n_bpl   = pwdata[15:0];
                ADDR_LINES: n_lines = pwdata[16:0];
                default:    n_bpl   = r_bpl;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpl   <= BPL_RESET;
            r_lines <= LINES_RESET;
        end else begin
            r_bpl   <= n_bpl;
            r_lines <= n_lines;
        end
    end

    assign prdata = (paddr[2] == ADDR_LINES) ? {15'd0, r_lines} : {16'd0, r_bpl};

    assign w_rearm.rearm = w_wr;
    assign w_rearm.bpl   = (n_bpl == 16'd0) ? 16'd1 : n_bpl;
    assign w_rearm.lines = (n_lines == 17'd0) ? 17'd1 : n_lines;

    pcxrle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rearm       (w_rearm),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    pcxrle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    pcxrle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("Command pushed into a full queue.");

    a_no_zero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_cmd.count != 6'd0))
        else $error("Empty run command queued.");

    a_image_end_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[2])
        else $error("Image end without line end on last pixel of run.");

    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[2] && !m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("Malformed error item.");

endmodule

// ----- hw/rtl/pcxrle_front.sv -----
// Front end: accepts code bytes, tracks line position and issues run commands.
module pcxrle_front
    import pcxrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rearm     i_rearm,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // code_byte
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic        r_expect, n_expect;
    logic [5:0]  r_pending, n_pending;
    logic [15:0] r_left, n_left;
    logic [16:0] r_lines, n_lines;
    logic        r_halted, n_halted;
    logic        w_acc;
    logic [5:0]  w_cnt;
    logic        w_le;
    logic        w_ie;
    logic        w_over;

    assign s_axis_tready = !i_full;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_cnt = r_expect ? r_pending : 6'd1;
    assign w_over = {10'd0, w_cnt} > r_left;
    assign w_le = ({10'd0, w_cnt} == r_left);
    assign w_ie = w_le && (r_lines == 17'd1);

    always_comb begin
        n_expect  = r_expect;
        n_pending = r_pending;
        n_left    = r_left;
        n_lines   = r_lines;
        n_halted  = r_halted;
        o_push    = 1'b0;
        o_cmd.pixel     = s_axis_tdata;
        o_cmd.count     = w_cnt;
        o_cmd.line_end  = w_le;
        o_cmd.image_end = w_ie;
        o_cmd.status    = 1'b0;
        if (w_acc && !r_halted) begin
            if (!r_expect && ((s_axis_tdata & CODE_MASK) == CODE_MASK)) begin
                n_pending = s_axis_tdata[5:0] & COUNT_MASK[5:0];
                n_expect  = 1'b1;
            end else begin
                n_expect  = 1'b0;
                n_pending = 6'd0;
                if (w_cnt != 6'd0) begin
                    o_push = 1'b1;
                    if (w_over) begin
                        o_cmd.pixel     = 8'd0;
                        o_cmd.count     = 6'd1;
                        o_cmd.line_end  = 1'b0;
                        o_cmd.image_end = 1'b0;
                        o_cmd.status    = 1'b1;
                        n_halted        = 1'b1;
                    end else if (w_le) begin
                        if (w_ie) begin
                            n_halted = 1'b1;
                            n_left   = 16'd0;
                        end else begin
                            n_lines = r_lines - 17'd1;
                            n_left  = i_rearm.bpl;
                        end
                    end else begin
                        n_left = r_left - {10'd0, w_cnt};
                    end
                end
            end
        end
        if (i_rearm.rearm) begin
            n_expect  = 1'b0;
            n_pending = 6'd0;
            n_left    = i_rearm.bpl;
            n_lines   = i_rearm.lines;
            n_halted  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect  <= 1'b0;
            r_pending <= 6'd0;
            r_left    <= BPL_RESET;
            r_lines   <= LINES_RESET;
            r_halted  <= 1'b0;
        end else begin
            r_expect  <= n_expect;
            r_pending <= n_pending;
            r_left    <= n_left;
            r_lines   <= n_lines;
            r_halted  <= n_halted;
        end
    end

endmodule

// ----- hw/rtl/pcxrle_fifo.sv -----
// Short command queue between the front end and the run expander.
module pcxrle_fifo
    import pcxrle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

endmodule

// ----- hw/rtl/pcxrle_back.sv -----
// Back end: expands queued run commands into pixel items, one per cycle while the output is not stalled.
module pcxrle_back
    import pcxrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // pixel
    output logic       m_axis_tlast,   // line_end
    output logic [2:0] m_axis_tuser    // image_end, status, run_last
);

    logic       r_busy, n_busy;
    t_cmd       r_cur, n_cur;
    logic [5:0] r_rem, n_rem;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_pix, n_pix;
    logic       r_le, n_le;
    logic [2:0] r_user, n_user;
    logic       w_adv;
    t_cmd       w_src;
    logic [5:0] w_left;
    logic       w_last;

    assign w_adv  = !r_ovalid || m_axis_tready;
    assign w_src  = r_busy ? r_cur : i_head;
    assign w_left = r_busy ? r_rem : i_head.count;
    assign w_last = (w_left == 6'd1);
    assign o_pop  = w_adv && !r_busy && !i_empty;

    always_comb begin
        n_busy   = r_busy;
        n_cur    = r_cur;
        n_rem    = r_rem;
        n_ovalid = r_ovalid;
        n_pix    = r_pix;
        n_le     = r_le;
        n_user   = r_user;
        if (w_adv) begin
            n_ovalid = r_busy || !i_empty;
            if (r_busy || !i_empty) begin
                n_pix  = w_src.pixel;
                n_le   = w_last && w_src.line_end;
                n_user = {w_last, w_src.status, w_last && w_src.image_end};
                n_cur  = w_src;
                n_rem  = w_left - 6'd1;
                n_busy = !w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_rem  <= n_rem;
        r_pix  <= n_pix;
        r_le   <= n_le;
        r_user <= n_user;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_pix;
    assign m_axis_tlast  = r_le;
    assign m_axis_tuser  = r_user;

endmodule
